FILE: rtl/rrps_pkg.sv
// rrps_pkg: shared types and constants of the round-robin process scheduler
// no dependencies

package rrps_pkg;

    localparam int          ID_W       = 8;
    localparam int          PRI_W      = 8;
    localparam int          TIME_W     = 10;
    localparam int          QUANTUM_W  = 8;
    localparam logic [TIME_W-1:0]    TIME_MAX      = 10'd1023;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd10;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    localparam logic REG_QUANTUM    = 1'b0;
    localparam logic REG_PRIO_ORDER = 1'b1;

    typedef enum logic [2:0] {
        ST_LOADED     = 3'd0,
        ST_FULL       = 3'd1,
        ST_REJECTED   = 3'd2,
        ST_DISPATCHED = 3'd3,
        ST_EMPTY      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_INSERT,
        OP_UPDATE,
        OP_REMOVE
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] used;
    } t_entry;

endpackage

FILE: rtl/rrps_cell.sv
// rrps_cell: one slot of the process table, shifts with its neighbors
// depends on rrps_pkg

module rrps_cell #(
    parameter int  DEPTH = 8,
    parameter int  IDX   = 0,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  rrps_pkg::t_cell_op i_op,
    input  logic [CW-1:0]      i_pos,
    input  logic [CW-1:0]      i_count,
    input  rrps_pkg::t_entry   i_new,
    input  rrps_pkg::t_entry   i_left,
    input  rrps_pkg::t_entry   i_right,
    output rrps_pkg::t_entry   o_entry,
    output logic               o_lower
);
    import rrps_pkg::*;

    localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
    localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_INSERT: begin
                if (MY_IDX == i_pos) begin
                    r_entry <= i_new;
                end else if (MY_IDX > i_pos && MY_IDX <= i_count) begin
                    r_entry <= i_left;
                end
            end
            OP_UPDATE: begin
                if (MY_IDX == i_pos) begin
                    r_entry <= i_new;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= i_pos && NEXT_IDX < i_count) begin
                    r_entry <= i_right;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_entry = r_entry;
    // occupied slot with lower priority than the incoming one
    assign o_lower = (MY_IDX < i_count) && (r_entry.pri < i_new.pri);

endmodule

FILE: rtl/round_robin_process_scheduler.sv
// round_robin_process_scheduler: top level, control sequencer over a row of table cells
// depends on rrps_pkg and rrps_cell
//
// Each beat passes through accept, table read at the serve pointer, table update and
// result beat; the sequencer handles one beat at a time, and the row of cells inserts
// or removes an entry by shifting the slots from its position on at once in the update cycle.

module round_robin_process_scheduler #(
    parameter int  TABLE_DEPTH = 8,
    localparam int IW          = $clog2(TABLE_DEPTH),
    localparam int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_addr,
    input  logic [rrps_pkg::QUANTUM_W-1:0] i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_mode,
    input  logic [rrps_pkg::PRI_W-1:0]     i_priority_req,
    input  logic [rrps_pkg::TIME_W-1:0]    i_need_time,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [2:0]                     o_status,
    output logic [rrps_pkg::ID_W-1:0]      o_process_id,
    output logic [rrps_pkg::TIME_W-1:0]    o_used_time,
    output logic [rrps_pkg::TIME_W-1:0]    o_remaining_time,
    output logic                           o_finished
);
    import rrps_pkg::*;

    t_state                r_state, n_state;
    logic                  r_mode;
    logic [PRI_W-1:0]      r_pri;
    logic [TIME_W-1:0]     r_need;
    logic [QUANTUM_W-1:0]  r_quantum;
    logic                  r_prio_order;
    logic [CW-1:0]         r_count, n_count;
    logic [IW-1:0]         r_ptr, n_ptr;
    logic [ID_W-1:0]       r_next_id, n_next_id;
    logic                  r_run, n_run;
    t_entry                r_rd;
    logic [IW-1:0]         r_pos;
    t_status               r_status, n_status;
    logic [ID_W-1:0]       r_pid, n_pid;
    logic [TIME_W-1:0]     r_used, n_used;
    logic [TIME_W-1:0]     r_rem, n_rem;
    logic                  r_fin, n_fin;

    t_entry                w_cell_q [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_lower;
    t_cell_op              w_op;
    logic [CW-1:0]         w_pos;
    logic [CW-1:0]         w_ins_pos;
    t_entry                w_new;
    logic [IW-1:0]         w_rd_idx;
    logic [TIME_W:0]       w_sum;
    logic [TIME_W-1:0]     w_sat;
    logic [TIME_W-1:0]     w_quantum;
    logic [CW-1:0]         w_cnt_dec;
    logic [CW-1:0]         w_inc;

    // row of table cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        rrps_cell #(
            .DEPTH (TABLE_DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_pos   (w_pos),
            .i_count (r_count),
            .i_new   (w_new),
            .i_left  ((g == 0) ? w_new : w_cell_q[(g == 0) ? 0 : g - 1]),
            .i_right ((g == TABLE_DEPTH - 1) ? w_new
                                             : w_cell_q[(g == TABLE_DEPTH - 1) ? g : g + 1]),
            .o_entry (w_cell_q[g]),
            .o_lower (w_lower[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE:  o_ready = 1'b1;
            S_OUT:   o_valid = 1'b1;
            default: begin
            end
        endcase
    end

    // first lower-priority slot, else the tail
    always_comb begin
        w_ins_pos = r_count;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (w_lower[i]) w_ins_pos = CW'(i);
        end
    end

    assign w_rd_idx  = (CW'(r_ptr) >= r_count) ? '0 : r_ptr;
    assign w_quantum = TIME_W'(r_quantum);
    assign w_sum     = (TIME_W + 1)'(r_rd.used) + (TIME_W + 1)'(r_quantum);
    assign w_sat     = (w_sum > (TIME_W + 1)'(TIME_MAX)) ? TIME_MAX : w_sum[TIME_W-1:0];
    assign w_cnt_dec = r_count - CW'(1);
    assign w_inc     = CW'(r_pos) + CW'(1);

    // entry written into the row: new process on load, served entry after its slice
    always_comb begin
        w_new = '{id: r_next_id, pri: r_pri, rem: r_need, used: '0};
        if (r_mode == MODE_DISPATCH) begin
            w_new = '{id: r_rd.id, pri: r_rd.pri, rem: r_rd.rem - w_quantum, used: w_sat};
        end
    end

    // table operation and result
    always_comb begin
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_next_id = r_next_id;
        n_run     = r_run;
        n_status  = ST_LOADED;
        n_pid     = '0;
        n_used    = '0;
        n_rem     = '0;
        n_fin     = 1'b0;
        w_op      = OP_NOP;
        w_pos     = CW'(r_pos);
        if (r_state == S_EXEC) begin
            if (r_mode == MODE_LOAD) begin
                if (r_run) begin
                    n_status = ST_REJECTED;
                end else if (r_count == CW'(TABLE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_op      = OP_INSERT;
                    w_pos     = r_prio_order ? w_ins_pos : r_count;
                    n_count   = r_count + CW'(1);
                    n_next_id = r_next_id + ID_W'(1);
                    n_status  = ST_LOADED;
                    n_pid     = r_next_id;
                end
            end else if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_run    = 1'b1;
                n_status = ST_DISPATCHED;
                n_pid    = r_rd.id;
                n_used   = r_rd.used;
                n_rem    = r_rd.rem;
                if (r_rd.rem <= w_quantum) begin
                    w_op    = OP_REMOVE;
                    n_fin   = 1'b1;
                    n_count = w_cnt_dec;
                    if (w_cnt_dec == '0) begin
                        n_run = 1'b0;
                        n_ptr = '0;
                    end else if (CW'(r_pos) >= w_cnt_dec) begin
                        n_ptr = '0;
                    end else begin
                        n_ptr = r_pos;
                    end
                end else begin
                    w_op  = OP_UPDATE;
                    n_ptr = (w_inc >= r_count) ? '0 : IW'(w_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_ptr        <= '0;
            r_next_id    <= '0;
            r_run        <= 1'b0;
            r_quantum    <= QUANTUM_RESET;
            r_prio_order <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_next_id <= n_next_id;
            r_run     <= n_run;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_QUANTUM:    r_quantum    <= i_cfg_wdata;
                    REG_PRIO_ORDER: r_prio_order <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_mode <= i_mode;
            r_pri  <= i_priority_req;
            r_need <= i_need_time;
        end
        if (r_state == S_READ) begin
            r_rd  <= w_cell_q[w_rd_idx];
            r_pos <= w_rd_idx;
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_pid    <= n_pid;
            r_used   <= n_used;
            r_rem    <= n_rem;
            r_fin    <= n_fin;
        end
    end

    assign o_status         = r_status;
    assign o_process_id     = r_pid;
    assign o_used_time      = r_used;
    assign o_remaining_time = r_rem;
    assign o_finished       = r_fin;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// testbench for round_robin_process_scheduler: directed and random load/dispatch beats
// checked against a cycle-free model of the process table; depends on rrps_pkg and the rtl

import rrps_pkg::*;

localparam int SLOT_COUNT = 8;

typedef struct packed {
    logic [2:0]        status;
    logic [ID_W-1:0]   process_id;
    logic [TIME_W-1:0] used_time;
    logic [TIME_W-1:0] remaining_time;
    logic              finished;
} t_slice_result;

class slice_tracker;
    t_entry               slot [SLOT_COUNT];
    int unsigned          count;
    int unsigned          ptr;
    logic [ID_W-1:0]      id_counter;
    bit                   running;
    logic [QUANTUM_W-1:0] quantum;
    bit                   by_priority;
    t_slice_result        expected_slices [$];
    int unsigned          mismatches;
    int unsigned          status_tally [5];
    int unsigned          completed;

    function new();
        count       = 0;
        ptr         = 0;
        id_counter  = '0;
        running     = 0;
        quantum     = QUANTUM_RESET;
        by_priority = 0;
        mismatches  = 0;
        completed   = 0;
        foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function void write_reg(input logic idx, input logic [QUANTUM_W-1:0] val);
        if (idx == REG_QUANTUM) quantum = val;
        else by_priority = val[0];
    endfunction

    function int unsigned entries();
        return count;
    endfunction

    function int unsigned pending();
        return expected_slices.size();
    endfunction

    // accepted input beat: advance the table and queue the result it causes
    function void note_beat(input logic mode, input logic [PRI_W-1:0] pri,
                            input logic [TIME_W-1:0] need);
        t_slice_result r;
        int unsigned   pos;
        int unsigned   p;
        int unsigned   sum;
        bit            found;
        r = '0;
        if (mode == MODE_LOAD) begin
            if (running) begin
                r.status = ST_REJECTED;
            end else if (count >= SLOT_COUNT) begin
                r.status = ST_FULL;
            end else begin
                pos   = count;
                found = 0;
                if (by_priority) begin
                    for (int i = 0; i < int'(count); i++) begin
                        if (!found && slot[i].pri < pri) begin
                            pos   = i;
                            found = 1;
                        end
                    end
                end
                for (int i = int'(count); i > int'(pos); i--) slot[i] = slot[i-1];
                slot[pos].id   = id_counter;
                slot[pos].pri  = pri;
                slot[pos].rem  = need;
                slot[pos].used = '0;
                count++;
                r.status     = ST_LOADED;
                r.process_id = id_counter;
                id_counter   = id_counter + ID_W'(1);
            end
        end else begin
            if (count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                running          = 1;
                p                = (ptr >= count) ? 0 : ptr;
                r.status         = ST_DISPATCHED;
                r.process_id     = slot[p].id;
                r.used_time      = slot[p].used;
                r.remaining_time = slot[p].rem;
                sum              = int'(slot[p].used) + int'(quantum);
                slot[p].used     = (sum > int'(TIME_MAX)) ? TIME_MAX : TIME_W'(sum);
                if (slot[p].rem <= TIME_W'(quantum)) begin
                    r.finished = 1'b1;
                    for (int i = int'(p); i + 1 < int'(count); i++) slot[i] = slot[i+1];
                    count--;
                    if (count == 0) begin
                        running = 0;
                        p       = 0;
                    end else if (p >= count) begin
                        p = 0;
                    end
                end else begin
                    slot[p].rem = slot[p].rem - TIME_W'(quantum);
                    p++;
                    if (p >= count) p = 0;
                end
                ptr = p;
            end
        end
        expected_slices.push_back(r);
    endfunction

    function void check_beat(input t_slice_result got);
        t_slice_result want;
        bit            bad;
        if (expected_slices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result beat with nothing expected: status %0d id %0d",
                         $time, got.status, got.process_id);
            return;
        end
        want = expected_slices.pop_front();
        bad  = (got.status !== want.status) || (got.process_id !== want.process_id) ||
               (got.used_time !== want.used_time) ||
               (got.remaining_time !== want.remaining_time) ||
               (got.finished !== want.finished);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $write("%0t: mismatch (exp/got) status %0d/%0d id %0d/%0d ", $time,
                       want.status, got.status, want.process_id, got.process_id);
                $display("used %0d/%0d rem %0d/%0d fin %0d/%0d",
                         want.used_time, got.used_time, want.remaining_time,
                         got.remaining_time, want.finished, got.finished);
            end
        end
        if (want.status <= ST_EMPTY) status_tally[want.status]++;
        if (want.finished) completed++;
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_addr  = 1'b0;
    logic [QUANTUM_W-1:0] cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 in_mode   = 1'b0;
    logic [PRI_W-1:0]     in_pri    = '0;
    logic [TIME_W-1:0]    in_need   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [2:0]           out_status;
    logic [ID_W-1:0]      out_process_id;
    logic [TIME_W-1:0]    out_used_time;
    logic [TIME_W-1:0]    out_remaining_time;
    logic                 out_finished;

    slice_tracker tracker = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_ack      = 0;
    int unsigned hold_left     = 0;
    int unsigned beats_sent    = 0;
    int unsigned quiet_cycles  = 0;

    round_robin_process_scheduler i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_addr       (cfg_addr),
        .i_cfg_wdata      (cfg_wdata),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_mode           (in_mode),
        .i_priority_req   (in_pri),
        .i_need_time      (in_need),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_status         (out_status),
        .o_process_id     (out_process_id),
        .o_used_time      (out_used_time),
        .o_remaining_time (out_remaining_time),
        .o_finished       (out_finished)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            out_ready <= 1'b0;
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // handshakes are stable from the falling edge up to the rising edge that takes them
    always @(negedge clk) begin
        t_slice_result seen;
        if (rst_n && out_valid && out_ready) begin
            seen.status         = out_status;
            seen.process_id     = out_process_id;
            seen.used_time      = out_used_time;
            seen.remaining_time = out_remaining_time;
            seen.finished       = out_finished;
            tracker.check_beat(seen);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_beat(input logic mode, input logic [PRI_W-1:0] pri,
                             input logic [TIME_W-1:0] need);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_pri   <= pri;
        in_need  <= need;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        tracker.note_beat(mode, pri, need);
        beats_sent++;
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [QUANTUM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        tracker.write_reg(idx, val);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic dispatch_until_empty();
        while (tracker.entries() != 0) send_beat(MODE_DISPATCH, 8'($urandom), 10'($urandom));
    endtask

    // keep the number of slices per process small for the current quantum
    function automatic logic [TIME_W-1:0] pick_need();
        int unsigned q;
        int unsigned span;
        q    = tracker.quantum;
        span = q * 12;
        if (span > TIME_MAX) span = TIME_MAX;
        case ($urandom_range(0, 9))
            0:       return TIME_W'(q);
            1:       return TIME_W'((q + 1 > span) ? span : q + 1);
            2:       return '0;
            3:       return TIME_W'(span);
            default: return TIME_W'($urandom_range(0, span));
        endcase
    endfunction

    function automatic logic [QUANTUM_W-1:0] pick_quantum();
        case ($urandom_range(0, 3))
            0:       return 8'd1;
            1:       return 8'd255;
            default: return QUANTUM_W'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic run_round();
        int unsigned n_loads;
        if ($urandom_range(0, 3) == 0) begin
            wait_results_drained();
            write_reg(REG_QUANTUM, pick_quantum());
            write_reg(REG_PRIO_ORDER, QUANTUM_W'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 6))
                send_beat(1'($urandom_range(0, 1)), 8'($urandom), pick_need());
        end else begin
            n_loads = $urandom_range(1, 10);
            repeat (n_loads) send_beat(MODE_LOAD, 8'($urandom), pick_need());
            while (tracker.entries() != 0) begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(MODE_LOAD, 8'($urandom), pick_need());
                else
                    send_beat(MODE_DISPATCH, 8'($urandom), 10'($urandom));
            end
            if ($urandom_range(0, 3) == 0) send_beat(MODE_DISPATCH, 8'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        logic [PRI_W-1:0]  dir_pri  [8];
        logic [TIME_W-1:0] dir_need [8];
        int unsigned       target;
        dir_pri  = '{8'd255, 8'd0, 8'd170, 8'd85, 8'd255, 8'd1, 8'd128, 8'd127};
        dir_need = '{10'd1023, 10'd0, 10'd1, 10'd255, 10'd256, 10'd2, 10'd3, 10'd4};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, full table, load during a run, end of run
        send_beat(MODE_DISPATCH, 8'hFF, 10'h3FF);
        wait_results_drained();
        write_reg(REG_QUANTUM, 8'd255);
        write_reg(REG_PRIO_ORDER, 8'd0);
        for (int i = 0; i < 8; i++) send_beat(MODE_LOAD, dir_pri[i], dir_need[i]);
        send_beat(MODE_LOAD, 8'hFF, 10'h3FF);
        send_beat(MODE_DISPATCH, 8'h00, 10'h000);
        send_beat(MODE_LOAD, 8'h00, 10'h000);
        dispatch_until_empty();

        // zero quantum with priority ties
        wait_results_drained();
        write_reg(REG_QUANTUM, 8'd0);
        write_reg(REG_PRIO_ORDER, 8'd1);
        send_beat(MODE_LOAD, 8'd5, 10'd0);
        send_beat(MODE_LOAD, 8'd9, 10'd20);
        send_beat(MODE_LOAD, 8'd5, 10'd30);
        repeat (3) send_beat(MODE_DISPATCH, 8'd0, 10'd0);
        wait_results_drained();
        write_reg(REG_QUANTUM, 8'd255);
        dispatch_until_empty();
        wait_results_drained();
        write_reg(REG_QUANTUM, QUANTUM_RESET);

        send_idle_pct = 33;
        recv_idle_pct = 67;
        hold_req++;
        target = beats_sent + 270;
        while (beats_sent < target) run_round();

        send_idle_pct = 67;
        recv_idle_pct = 33;
        target = beats_sent + 270;
        while (beats_sent < target) run_round();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        target = beats_sent + 270;
        while (beats_sent < target) run_round();

        wait_results_drained();
        repeat (8) @(posedge clk);

        $display("%0d beats: %0d loads, %0d full, %0d rejected, %0d empty dispatches",
                 beats_sent, tracker.status_tally[ST_LOADED], tracker.status_tally[ST_FULL],
                 tracker.status_tally[ST_REJECTED], tracker.status_tally[ST_EMPTY]);
        $display("%0d time slices served, %0d processes completed, %0d mismatches",
                 tracker.status_tally[ST_DISPATCHED], tracker.completed, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
